// ----- rtl/awst_pkg.sv -----
// ----------------------------------------------------------------------------
// awst_pkg: shared types and constants of the availability-window timer
// Holds field widths, function and register codes, and the structs that
// connect the sequencer to the bit-serial divider.
// ----------------------------------------------------------------------------
package awst_pkg;

    // Item fields
    localparam int FUNC_W  = 2;
    localparam int TIME_W  = 64;
    localparam int TU_W    = 16;
    localparam int CNT_W   = 16;
    localparam int US_W    = 22;
    localparam int ERR_W   = 32;

    // Configuration
    localparam int PERIOD_W    = 8;
    localparam int MODE_W      = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOWS_PER_EXT = 2'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd16;
    localparam logic [MODE_W-1:0]   MODE_RESET   = 5'd4;
    localparam logic [MODE_W-1:0]   MODE_MAX     = 5'd16;

    // Function codes; any other code is a plain query
    localparam logic [FUNC_W-1:0] FUNC_SYNC    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // 1 TU = 1024 us
    localparam int TU_SHIFT = 10;
    localparam logic [CNT_W-1:0] COUNT_MASK = 16'hfffc;

    // Extended period in TU: at most 16 * 255 = 4080
    localparam int EXT_W = 12;

    // Serial divider: dividend is left aligned in a T_W-bit shift register
    localparam int T_W    = TIME_W - TU_SHIFT;
    localparam int REM_W  = EXT_W;
    localparam int STEP_W = 6;

    typedef struct packed {
        logic               start;
        logic [T_W-1:0]     dividend;
        logic [REM_W-1:0]   divisor;
        logic [STEP_W-1:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [T_W-1:0]     quo;
        logic [REM_W-1:0]   rem;
    } div_rsp_t;

endpackage

// ----- rtl/awst_ifs.sv -----
// ----------------------------------------------------------------------------
// awst_ifs: valid/ready channels of the availability-window timer
// Query items in, report items out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface awst_query_if;
    import awst_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TIME_W-1:0]   now_us;
    logic [TU_W-1:0]     peer_time_to_next_tu;
    logic [CNT_W-1:0]    peer_window_count;

    modport source (output valid, func, now_us, peer_time_to_next_tu,
                    peer_window_count, input ready);
    modport sink   (input valid, func, now_us, peer_time_to_next_tu,
                    peer_window_count, output ready);
endinterface

interface awst_report_if;
    import awst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TU_W-1:0]          next_window_tu;
    logic [US_W-1:0]          next_window_us;
    logic [CNT_W-1:0]         current_window;
    logic [CNT_W-1:0]         current_extended;
    logic signed [ERR_W-1:0]  sync_error_tu;

    modport source (output valid, next_window_tu, next_window_us, current_window,
                    current_extended, sync_error_tu, input ready);
    modport sink   (input valid, next_window_tu, next_window_us, current_window,
                    current_extended, sync_error_tu, output ready);
endinterface

interface awst_cfg_if;
    import awst_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/awst_serdiv.sv -----
// ----------------------------------------------------------------------------
// awst_serdiv: restoring divider, one quotient bit per cycle
// Takes a left-aligned dividend and a step count; once that many steps have
// run, the quotient sits in the low bits of quo and the remainder in rem.
// ----------------------------------------------------------------------------
module awst_serdiv (
    input  logic               clk,
    input  logic               rst_n,
    input  awst_pkg::div_req_t req,
    output awst_pkg::div_rsp_t rsp
);
    import awst_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   count_reg, count_next;
    logic [REM_W-1:0]    divisor_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [T_W-1:0]      quo_reg;

    logic [REM_W:0]      shifted;
    logic [REM_W+1:0]    trial;
    logic                take;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign shifted = {rem_reg, quo_reg[T_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor_reg};
    assign take    = !trial[REM_W+1];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = req.steps;
        end
        else if (busy_reg)
        begin
            count_next = count_reg - 1'b1;
            if (count_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? trial[REM_W-1:0] : shifted[REM_W-1:0];
            quo_reg <= {quo_reg[T_W-2:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < divisor_reg))
        else $error("partial remainder not below divisor");

    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("divider run ended without done");
`endif

endmodule

// ----- rtl/availability_window_sync_timer_core.sv -----
// ----------------------------------------------------------------------------
// availability_window_sync_timer_core: availability-window sync timer
// Tracks a sync reference point and reports the time to the next extended
// window, window numbers and the sync error against a peer for every item.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake         contents
//  --------  ----  ----------------  -----------------------------------------
//  query     in    valid / ready     func, now_us, peer time and window count
//  report    out   valid / ready     next window TU/us, window numbers, error
//  cfg       in    valid / ready     index, data (window period, presence mode)
//
//  Between acceptance and result an item goes through the serial divider:
//  it runs 54 steps for the elapsed TU over the extended period, then 12,
//  16 and 16 steps for the window, peer and extended-window quotients.
//  Reset clears the reference point to time zero with window count zero and
//  loads the register defaults. A new query is taken as soon as the previous
//  result sits in the report register; a stalled report holds the item in
//  the final step until the register frees up. cfg is always ready.
//
module availability_window_sync_timer_core (
    input  logic        clk,
    input  logic        rst_n,
    awst_query_if.sink  query,
    awst_report_if.source report,
    awst_cfg_if.sink    cfg
);
    import awst_pkg::*;

    // One-hot sequencer: GO states issue a divider start, RUN states wait
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_T_GO  = 12'b0000_0000_0010,
        ST_T_RUN = 12'b0000_0000_0100,
        ST_W_GO  = 12'b0000_0000_1000,
        ST_W_RUN = 12'b0000_0001_0000,
        ST_CUR   = 12'b0000_0010_0000,
        ST_P_GO  = 12'b0000_0100_0000,
        ST_P_RUN = 12'b0000_1000_0000,
        ST_C_GO  = 12'b0001_0000_0000,
        ST_C_RUN = 12'b0010_0000_0000,
        ST_MUL   = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration and reference point
    logic [PERIOD_W-1:0] period_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [TIME_W-1:0]   ref_time_reg;
    logic [CNT_W-1:0]    ref_cnt_reg;

    // Item under work
    logic [FUNC_W-1:0]   func_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TU_W-1:0]     peer_tu_reg;
    logic [CNT_W-1:0]    peer_cnt_reg;
    logic [T_W-1:0]      t_reg;
    logic [TU_SHIFT-1:0] dlo_reg;
    logic [PERIOD_W-1:0] p_reg;
    logic [MODE_W-1:0]   m_reg;
    logic [EXT_W-1:0]    e_reg;
    logic [REM_W-1:0]    r_reg;
    logic [CNT_W-1:0]    qlo_reg;
    logic [MODE_W-2:0]   wq_reg;
    logic [CNT_W-1:0]    cur_reg;
    logic [CNT_W-1:0]    pext_reg;
    logic [CNT_W-1:0]    cext_reg;
    logic signed [29:0]  prod_reg;

    // Report register
    logic                    out_valid_reg, out_valid_next;
    logic [TU_W-1:0]         out_tu_reg;
    logic [US_W-1:0]         out_us_reg;
    logic [CNT_W-1:0]        out_cur_reg;
    logic [CNT_W-1:0]        out_ext_reg;
    logic signed [ERR_W-1:0] out_err_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                 q_fire;
    logic                 fin_fire;
    logic [PERIOD_W-1:0]  p_eff;
    logic [MODE_W-1:0]    m_eff;
    logic [12:0]          e_full;
    logic [TIME_W-1:0]    d_now;
    logic [20:0]          mq_full;
    logic signed [16:0]   ext_diff;
    logic signed [12:0]   e_signed;
    logic signed [29:0]   prod_full;
    logic [EXT_W-1:0]     nxt_tu;
    logic [US_W-1:0]      nxt_us;
    logic signed [16:0]   tu_gap;
    logic signed [29:0]   err_full;
    logic [16:0]          lead_tu;
    logic [TIME_W-1:0]    lead_us;

    assign query.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign q_fire      = query.valid && query.ready;
    assign fin_fire    = (state_reg == ST_FIN) && (!out_valid_reg || report.ready);

    // Zero period acts as one; presence mode clamps to 1..16
    assign p_eff  = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign m_eff  = (mode_reg == '0) ? MODE_W'(1)
                  : ((mode_reg > MODE_MAX) ? MODE_MAX : mode_reg);
    assign e_full = {5'b0, p_eff} * {8'b0, m_eff};
    assign d_now  = query.now_us - ref_time_reg;

    // Window advance: whole extended periods times presence mode
    assign mq_full = {16'b0, m_reg} * {5'b0, qlo_reg};

    // Sync error pieces
    assign ext_diff  = $signed({1'b0, pext_reg}) - $signed({1'b0, cext_reg});
    assign e_signed  = $signed({1'b0, e_reg});
    assign prod_full = ext_diff * e_signed;
    assign nxt_tu    = e_reg - r_reg;
    assign nxt_us    = {nxt_tu, {TU_SHIFT{1'b0}}} - {{(US_W-TU_SHIFT){1'b0}}, dlo_reg};
    assign tu_gap    = $signed({1'b0, peer_tu_reg}) - $signed({5'b0, nxt_tu});
    assign err_full  = prod_reg - {{13{tu_gap[16]}}, tu_gap};

    // Peer lead in TU may be negative: sign extend before scaling to us
    assign lead_tu = {5'b0, e_reg} - {1'b0, peer_tu_reg};
    assign lead_us = {{(TIME_W-17-TU_SHIFT){lead_tu[16]}}, lead_tu, {TU_SHIFT{1'b0}}};

    // Operands for the shared divider, left aligned
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.steps    = '0;
        unique case (state_reg)
            ST_T_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = t_reg;
                div_req.divisor  = e_reg;
                div_req.steps    = STEP_W'(T_W);
            end
            ST_W_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_reg, {(T_W-REM_W){1'b0}}};
                div_req.divisor  = {{(REM_W-PERIOD_W){1'b0}}, p_reg};
                div_req.steps    = STEP_W'(REM_W);
            end
            ST_P_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {peer_cnt_reg, {(T_W-CNT_W){1'b0}}};
                div_req.divisor  = {{(REM_W-MODE_W){1'b0}}, m_reg};
                div_req.steps    = STEP_W'(CNT_W);
            end
            ST_C_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {cur_reg, {(T_W-CNT_W){1'b0}}};
                div_req.divisor  = {{(REM_W-MODE_W){1'b0}}, m_reg};
                div_req.steps    = STEP_W'(CNT_W);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    awst_serdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_fire) state_next = ST_T_GO;
            ST_T_GO:  state_next = ST_T_RUN;
            ST_T_RUN: if (div_rsp.done) state_next = ST_W_GO;
            ST_W_GO:  state_next = ST_W_RUN;
            ST_W_RUN: if (div_rsp.done) state_next = ST_CUR;
            ST_CUR:   state_next = ST_P_GO;
            ST_P_GO:  state_next = ST_P_RUN;
            ST_P_RUN: if (div_rsp.done) state_next = ST_C_GO;
            ST_C_GO:  state_next = ST_C_RUN;
            ST_C_RUN: if (div_rsp.done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_FIN;
            ST_FIN:   if (fin_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Report register: load on finish, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            period_reg    <= PERIOD_RESET;
            mode_reg      <= MODE_RESET;
            ref_time_reg  <= '0;
            ref_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_WINDOW_PERIOD:   period_reg <= cfg.data;
                    CFG_WINDOWS_PER_EXT: mode_reg   <= cfg.data[MODE_W-1:0];
                    default:             ;
                endcase
            end
            // Move the reference point once the result is out
            if (fin_fire)
            begin
                unique case (func_reg)
                    FUNC_SYNC:
                    begin
                        ref_time_reg <= now_reg - lead_us;
                        ref_cnt_reg  <= peer_cnt_reg & COUNT_MASK;
                    end
                    FUNC_RESTART:
                    begin
                        ref_time_reg <= now_reg;
                        ref_cnt_reg  <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath: hold the item and collect the divider results
    always_ff @(posedge clk)
    begin
        if (q_fire)
        begin
            func_reg     <= query.func;
            now_reg      <= query.now_us;
            peer_tu_reg  <= query.peer_time_to_next_tu;
            peer_cnt_reg <= query.peer_window_count;
            t_reg        <= d_now[TIME_W-1:TU_SHIFT];
            dlo_reg      <= d_now[TU_SHIFT-1:0];
            p_reg        <= p_eff;
            m_reg        <= m_eff;
            e_reg        <= e_full[EXT_W-1:0];
        end
        if ((state_reg == ST_T_RUN) && div_rsp.done)
        begin
            r_reg   <= div_rsp.rem;
            qlo_reg <= div_rsp.quo[CNT_W-1:0];
        end
        if ((state_reg == ST_W_RUN) && div_rsp.done)
        begin
            wq_reg <= div_rsp.quo[MODE_W-2:0];
        end
        if (state_reg == ST_CUR)
        begin
            cur_reg <= ref_cnt_reg + {{(CNT_W-MODE_W+1){1'b0}}, wq_reg}
                       + mq_full[CNT_W-1:0];
        end
        if ((state_reg == ST_P_RUN) && div_rsp.done)
        begin
            pext_reg <= div_rsp.quo[CNT_W-1:0];
        end
        if ((state_reg == ST_C_RUN) && div_rsp.done)
        begin
            cext_reg <= div_rsp.quo[CNT_W-1:0];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_full;
        end
        if (fin_fire)
        begin
            out_tu_reg  <= {{(TU_W-EXT_W){1'b0}}, nxt_tu};
            out_us_reg  <= nxt_us;
            out_cur_reg <= cur_reg;
            out_ext_reg <= cext_reg;
            out_err_reg <= {{(ERR_W-30){err_full[29]}}, err_full};
        end
    end

    assign report.valid            = out_valid_reg;
    assign report.next_window_tu   = out_tu_reg;
    assign report.next_window_us   = out_us_reg;
    assign report.current_window   = out_cur_reg;
    assign report.current_extended = out_ext_reg;
    assign report.sync_error_tu    = out_err_reg;

`ifndef SYNTHESIS
    a_ref_count_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ref_cnt_reg[1:0] == 2'b00)
        else $error("reference window count not aligned to four");

    a_next_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid |-> (report.next_window_tu != '0))
        else $error("time to next window reported as zero");

    a_no_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_rsp.done)
        else $error("divider finished with no item in work");
`endif

endmodule

// ----- sim/availability_window_sync_timer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// availability_window_sync_timer_core_tb: self-checking bench of the sync timer
// Offers query items under random gaps and back-pressure and tracks the sync
// reference point and window registers on its own side. It predicts every
// report item and compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module availability_window_sync_timer_core_tb;
    import awst_pkg::*;

    // Codes the package leaves unnamed: plain query and the spare function code
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int TAIL_CYCLES     = 150;
    localparam int BATCH_ITEMS     = 50;

    localparam longint ERR_MAX = 64'sd2147483647;
    localparam longint ERR_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] now_us;
        logic [TU_W-1:0]   peer_tu;
        logic [CNT_W-1:0]  peer_cnt;
    } query_t;

    typedef struct packed {
        logic [TU_W-1:0]         next_tu;
        logic [US_W-1:0]         next_us;
        logic [CNT_W-1:0]        cur_window;
        logic [CNT_W-1:0]        cur_ext;
        logic signed [ERR_W-1:0] sync_err;
    } report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    awst_query_if  query_ch ();
    awst_report_if report_ch ();
    awst_cfg_if    cfg_ch ();

    availability_window_sync_timer_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .report (report_ch),
        .cfg    (cfg_ch)
    );

    always #CLK_HALF clk = ~clk;

    // Local copy of the registers and the sync reference point
    logic [PERIOD_W-1:0] cfg_period  = PERIOD_RESET;
    logic [MODE_W-1:0]   cfg_mode    = MODE_RESET;
    logic [TIME_W-1:0]   ref_time_us = '0;
    logic [CNT_W-1:0]    ref_window  = '0;

    // Reports owed by the block, oldest first
    report_t reports_due[$];

    int   fail_count    = 0;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    logic rx_hold       = 1'b0;

    // Running time base of the well-formed traffic
    logic [TIME_W-1:0] stim_now = '0;

    // Window period as the block uses it: zero counts as one TU
    function automatic logic [63:0] eff_period_tu();
        logic [63:0] v;
        v = cfg_period;
        return (v == 64'd0) ? 64'd1 : v;
    endfunction

    // Presence mode as the block uses it: clamp into one to sixteen windows
    function automatic logic [63:0] eff_mode();
        logic [63:0] v;
        logic [63:0] top;
        v = cfg_mode;
        top = MODE_MAX;
        if (v == 64'd0)
        begin
            return 64'd1;
        end
        return (v > top) ? top : v;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer one query item, hold it until accepted, then predict its
    // report from the state as it stood before the item and advance the state.
    // valid stays high on return so back-to-back items need not drop it.
    // ------------------------------------------------------------------------
    task automatic offer_query(input query_t q);
        logic [63:0] per;
        logic [63:0] mode;
        logic [63:0] ext;
        logic [63:0] ext_us;
        logic [63:0] elapsed;
        logic [63:0] elapsed_tu;
        logic [63:0] phase_tu;
        logic [63:0] wide;
        logic [63:0] peer_tu_w;
        logic [63:0] peer_cnt_w;
        longint      err;
        report_t     r;

        // Insert random gaps before the item
        while ($urandom_range(99) < src_idle_pct)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
        end
        query_ch.valid                <= 1'b1;
        query_ch.func                 <= q.func;
        query_ch.now_us               <= q.now_us;
        query_ch.peer_time_to_next_tu <= q.peer_tu;
        query_ch.peer_window_count    <= q.peer_cnt;
        @(posedge clk);
        while (!query_ch.ready)
        begin
            @(posedge clk);
        end

        // Accepted: work out the report
        per        = eff_period_tu();
        mode       = eff_mode();
        ext        = per * mode;
        ext_us     = ext << TU_SHIFT;
        peer_tu_w  = q.peer_tu;
        peer_cnt_w = q.peer_cnt;
        elapsed    = q.now_us - ref_time_us;
        elapsed_tu = elapsed >> TU_SHIFT;
        phase_tu   = elapsed_tu % ext;

        wide = ext - phase_tu;
        r.next_tu = wide[TU_W-1:0];
        wide = ext_us - (elapsed % ext_us);
        r.next_us = wide[US_W-1:0];
        wide = {48'd0, ref_window} + phase_tu / per + mode * (elapsed_tu / ext);
        r.cur_window = wide[CNT_W-1:0];
        wide = {48'd0, r.cur_window} / mode;
        r.cur_ext = wide[CNT_W-1:0];

        // Signed error against the peer, clipped to 32 bits
        err = (longint'(peer_cnt_w / mode) - longint'({48'd0, r.cur_ext})) * longint'(ext)
              - (longint'(peer_tu_w) - longint'({48'd0, r.next_tu}));
        if (err > ERR_MAX)
        begin
            err = ERR_MAX;
        end
        if (err < ERR_MIN)
        begin
            err = ERR_MIN;
        end
        r.sync_err = err[ERR_W-1:0];
        reports_due.push_back(r);

        // Move the reference point; a peer value above the extended period moves it ahead
        if (q.func == FUNC_SYNC)
        begin
            ref_time_us = q.now_us - ((ext - peer_tu_w) << TU_SHIFT);
            ref_window  = q.peer_cnt & COUNT_MASK;
        end
        else if (q.func == FUNC_RESTART)
        begin
            ref_time_us = q.now_us;
            ref_window  = '0;
        end
    endtask

    // Drop the query valid and hold until every owed report has arrived;
    // always wait for a clock edge first so the caller drives on a fresh step
    task automatic drain_reports();
        query_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (reports_due.size() != 0);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        if (index == CFG_WINDOW_PERIOD)
        begin
            cfg_period = data;
        end
        else if (index == CFG_WINDOWS_PER_EXT)
        begin
            cfg_mode = data[MODE_W-1:0];
        end
    endtask

    // Load both registers, poke one spare index, then drop valid.
    // Call only with the block idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] period_data,
                              input logic [CFG_DATA_W-1:0] mode_data);
        logic [CFG_INDEX_W-1:0] spare;
        spare = ($urandom_range(1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
        write_cfg(CFG_WINDOW_PERIOD, period_data);
        write_cfg(CFG_WINDOWS_PER_EXT, mode_data);
        write_cfg(spare, 8'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall at random, or hard while a hold-off is running
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        report_ch.ready <= !rx_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // Match every accepted report against the oldest owed one
    always @(posedge clk)
    begin : report_check
        report_t want;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected report: next_window_tu %0d, current_window %0d",
                       report_ch.next_window_tu, report_ch.current_window);
                fail_count++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("next_window_tu", longint'(want.next_tu),
                            longint'(report_ch.next_window_tu));
                check_field("next_window_us", longint'(want.next_us),
                            longint'(report_ch.next_window_us));
                check_field("current_window", longint'(want.cur_window),
                            longint'(report_ch.current_window));
                check_field("current_extended", longint'(want.cur_ext),
                            longint'(report_ch.current_extended));
                check_field("sync_error_tu", longint'($signed(want.sync_err)),
                            longint'($signed(report_ch.sync_error_tu)));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reference at zero with default registers: zero elapsed time, then the
    // largest elapsed time with the spare function code and all-ones peer
    task automatic test_reset_defaults();
        offer_query('{FUNC_QUERY, 64'd0, 16'd0, 16'd0});
        offer_query('{FUNC_UNUSED, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff});
        drain_reports();
    endtask

    // Sync updates, a peer ahead of the extended period, restart near the
    // top of the time range and a query that wraps past zero
    task automatic test_sync_and_restart();
        offer_query('{FUNC_SYNC, 64'd1_000_000, 16'd0, 16'hffff});
        offer_query('{FUNC_QUERY, 64'd1_070_000, 16'd3, 16'hfffc});
        offer_query('{FUNC_SYNC, 64'd2_000_000, 16'hffff, 16'h0001});
        offer_query('{FUNC_QUERY, 64'd2_000_000, 16'h8000, 16'h8000});
        offer_query('{FUNC_RESTART, 64'hffff_ffff_ffff_fc00, 16'h00ff, 16'h1234});
        offer_query('{FUNC_QUERY, 64'h0000_0000_0001_0000, 16'h0000, 16'h0000});
        offer_query('{FUNC_UNUSED, 64'h8000_0000_0000_0000, 16'h7fff, 16'h7fff});
        drain_reports();
    endtask

    // Zero period, zero mode, largest period and mode, mode above sixteen,
    // and mode data with the upper bits set
    task automatic test_config_extremes();
        logic [CFG_DATA_W-1:0] periods [5];
        logic [CFG_DATA_W-1:0] modes [5];
        periods = '{8'd0, 8'd255, 8'd255, 8'd1, 8'd128};
        modes   = '{8'd0, 8'd16, 8'd31, 8'd17, 8'he0};
        for (int k = 0; k < 5; k++)
        begin
            set_config(periods[k], modes[k]);
            offer_query('{FUNC_QUERY, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'h0000});
            offer_query('{FUNC_SYNC, 64'd5_000_000_000, 16'd0, 16'hffff});
            drain_reports();
        end
    endtask

    // Mostly well-formed traffic: restart, then queries, syncs, restarts and
    // spare codes with time moving forward by up to three extended periods or
    // by a rare large jump; the rest is noise. Reload the registers every batch.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        query_t            q;
        logic [63:0]       ext;
        logic [63:0]       ext_us;
        logic [CFG_DATA_W-1:0] period_data;
        logic [CFG_DATA_W-1:0] mode_data;
        int unsigned       span;
        int                pick;
        int                kind;

        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % BATCH_ITEMS == 0)
            begin
                drain_reports();
                pick = $urandom_range(9);
                if (pick < 2)
                begin
                    period_data = ($urandom_range(1) == 0) ? 8'd1 : 8'd255;
                end
                else if (pick < 5)
                begin
                    period_data = 8'($urandom);
                end
                else
                begin
                    period_data = 8'($urandom_range(32, 1));
                end
                mode_data = ($urandom_range(9) < 7) ? 8'($urandom_range(16, 1))
                                                   : 8'($urandom);
                set_config(period_data, mode_data);

                // Fresh reference, sometimes just below the wrap point
                if ($urandom_range(3) == 0)
                begin
                    stim_now = 64'hffff_ffff_ff00_0000 | 64'($urandom_range(24'hffffff));
                end
                else
                begin
                    stim_now = {$urandom, $urandom};
                end
                offer_query('{FUNC_RESTART, stim_now, 16'($urandom), 16'($urandom)});
            end

            ext    = eff_period_tu() * eff_mode();
            ext_us = ext << TU_SHIFT;
            span   = ext_us[31:0] * 3;
            pick   = $urandom_range(99);
            if (pick < 85)
            begin
                if (pick < 4)
                begin
                    stim_now = stim_now + (64'($urandom) << 8);
                end
                else
                begin
                    stim_now = stim_now + 64'($urandom_range(span, 0));
                end
                kind = $urandom_range(99);
                q.now_us   = stim_now;
                q.peer_cnt = 16'($urandom);
                if (kind < 50)
                begin
                    q.func    = FUNC_QUERY;
                    q.peer_tu = 16'($urandom);
                end
                else if (kind < 85)
                begin
                    // Peer reports a plausible time to its next window
                    q.func    = FUNC_SYNC;
                    q.peer_tu = ($urandom_range(9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(ext[31:0], 0));
                end
                else if (kind < 93)
                begin
                    q.func    = FUNC_RESTART;
                    q.peer_tu = 16'($urandom);
                end
                else
                begin
                    q.func    = FUNC_UNUSED;
                    q.peer_tu = 16'($urandom);
                end
            end
            else
            begin
                q.func     = 2'($urandom);
                q.now_us   = {$urandom, $urandom};
                q.peer_tu  = 16'($urandom);
                q.peer_cnt = 16'($urandom);
            end
            offer_query(q);
        end
        drain_reports();
    endtask

    // Block the report side for a long stretch while items keep coming, so the
    // block fills up and stalls its query input
    task automatic test_receiver_hold_off();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            for (int i = 0; i < 30; i++)
            begin
                stim_now = stim_now + 64'd7000;
                offer_query('{FUNC_QUERY, stim_now, 16'($urandom), 16'($urandom)});
            end
        join
        drain_reports();
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial
    begin : run
        query_ch.valid                = 1'b0;
        query_ch.func                 = FUNC_QUERY;
        query_ch.now_us               = '0;
        query_ch.peer_time_to_next_tu = '0;
        query_ch.peer_window_count    = '0;
        report_ch.ready               = 1'b0;
        cfg_ch.valid                  = 1'b0;
        cfg_ch.index                  = CFG_WINDOW_PERIOD;
        cfg_ch.data                   = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_sync_and_restart();
        test_config_extremes();

        // Sender rarely idle and receiver mostly stalled, then swap, then none
        test_random_traffic(9, 61, 300);
        test_random_traffic(61, 9, 300);
        test_random_traffic(0, 0, 300);
        test_receiver_hold_off();

        // Let any stray report show up before judging
        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && reports_due.size() == 0)
        begin
            $display("availability_window_sync_timer_core verification clean");
        end
        else
        begin
            $display("availability_window_sync_timer_core verification failed");
        end
        $finish;
    end

    // Give up if the run hangs
    initial
    begin : watchdog
        #20_000_000;
        $display("availability_window_sync_timer_core verification failed");
        $finish;
    end

endmodule
